/* rtl/smsort_pkg.sv */
// ----------------------------------------------------------------------------
// smsort_pkg
// shared types and field widths for the stable merge sort core
// ----------------------------------------------------------------------------
package smsort_pkg;

    localparam int COST_W = 16;
    localparam int TAG_W  = 16;
    localparam int ITEM_W = COST_W + TAG_W;

    typedef logic [COST_W-1:0] cost_t;
    typedef logic [TAG_W-1:0]  tag_t;

    typedef struct packed {
        tag_t  tag;
        cost_t cost;
    } item_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PASS,
        ST_RUN,
        ST_MRD,
        ST_MWR,
        ST_ERD,
        ST_EOUT
    } state_t;

endpackage

/* rtl/smsort_ram.sv */
// ----------------------------------------------------------------------------
// smsort_ram
// generic ram, one write port, two registered read ports
// ----------------------------------------------------------------------------
module smsort_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

/* rtl/stable_merge_sort_core.sv */
// ----------------------------------------------------------------------------
// stable_merge_sort_core
// batch sorter for (cost, tag) pairs, stable bottom-up merge over two banks
// ----------------------------------------------------------------------------
// the slave channel loads one beat per cycle into bank 0; the beat with
// tlast closes the batch and tready drops until the whole batch has been
// handed to the master output register. beats beyond MAX_ITEMS are dropped
// and flag tuser on every result of that batch.
// sorting runs ceil(log2 n) passes between the two banks with one shared
// comparator; each pass reads, then compares and writes one element at a
// time, with a setup step for each run and for each pass; with n = 64
// there are six passes.
// each beat is emitted by a ram read and then an output register load; the
// read for the next beat starts only once the current beat is loaded.
// the master side has one output register: a stalled receiver holds the
// current beat and freezes emission, nothing is lost or repeated.
// reset (rst_n low) empties the batch, clears the output valid flag and
// returns to loading; ram contents need no clearing since only entries
// written in the current batch are ever used.
// ----------------------------------------------------------------------------
module stable_merge_sort_core
    import smsort_pkg::*;
#(
    parameter int MAX_ITEMS = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [31:0]       s_axis_tdata,   // cost[15:0], item_tag[31:16]
    input  logic              s_axis_tlast,   // last
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [31:0]       m_axis_tdata,   // sorted_cost[15:0], sorted_tag[31:16]
    output logic              m_axis_tlast,   // end_of_run
    output logic              m_axis_tuser    // overflow
);

    localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
    localparam int ADDR_W = $clog2(MAX_ITEMS);
    localparam int SUM_W  = CNT_W + 2;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ITEMS);

    state_t state_reg, state_next;

    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [CNT_W:0]   w_reg, w_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic [CNT_W-1:0] mid_reg, mid_next;
    logic [CNT_W-1:0] hi_reg, hi_next;
    logic             src_reg, src_next;

    logic             out_valid_reg, out_valid_next;
    item_t            out_data_reg, out_data_next;
    logic             out_last_reg, out_last_next;
    logic             out_ovf_reg, out_ovf_next;

    logic              b0_we, b1_we;
    logic [ADDR_W-1:0] waddr, raddr_a, raddr_b;
    item_t             wdata;
    item_t             b0_rda, b0_rdb, b1_rda, b1_rdb;
    item_t             left_item, right_item;

    logic              in_beat, store_ok, out_free, take_left, pass_done;
    logic [SUM_W-1:0]  sum_w, sum_2w, n_ext;

    assign in_beat   = s_axis_tvalid && s_axis_tready;
    assign store_ok  = count_reg < MAX_CNT;
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign left_item  = src_reg ? b1_rda : b0_rda;
    assign right_item = src_reg ? b1_rdb : b0_rdb;
    assign take_left  = (i_reg < mid_reg)
                        && ((j_reg >= hi_reg) || (left_item.cost <= right_item.cost));
    assign pass_done = (k_reg == n_reg);
    assign sum_w     = SUM_W'(k_reg) + SUM_W'(w_reg);
    assign sum_2w    = SUM_W'(k_reg) + (SUM_W'(w_reg) << 1);
    assign n_ext     = SUM_W'(n_reg);

    assign s_axis_tready = (state_reg == ST_LOAD);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_ovf_reg;

    smsort_ram #(.WIDTH(ITEM_W), .DEPTH(MAX_ITEMS)) u_bank0 (
        .clk     (clk),
        .we      (b0_we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .rdata_a (b0_rda),
        .raddr_b (raddr_b),
        .rdata_b (b0_rdb)
    );

    smsort_ram #(.WIDTH(ITEM_W), .DEPTH(MAX_ITEMS)) u_bank1 (
        .clk     (clk),
        .we      (b1_we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .rdata_a (b1_rda),
        .raddr_b (raddr_b),
        .rdata_b (b1_rdb)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_beat && s_axis_tlast)
                begin
                    state_next = ST_PASS;
                end
            end
            ST_PASS:
            begin
                if (w_reg >= (CNT_W+1)'(n_reg))
                begin
                    state_next = ST_ERD;
                end
                else
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                state_next = pass_done ? ST_PASS : ST_MRD;
            end
            ST_MRD:
            begin
                state_next = ST_MWR;
            end
            ST_MWR:
            begin
                state_next = (k_reg + 1'b1 == hi_reg) ? ST_RUN : ST_MRD;
            end
            ST_ERD:
            begin
                state_next = ST_EOUT;
            end
            ST_EOUT:
            begin
                if (out_free)
                begin
                    state_next = (k_reg + 1'b1 == n_reg) ? ST_LOAD : ST_ERD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // datapath and ram control
    always_comb
    begin
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        n_next         = n_reg;
        w_next         = w_reg;
        k_next         = k_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        mid_next       = mid_reg;
        hi_next        = hi_reg;
        src_next       = src_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;
        b0_we          = 1'b0;
        b1_we          = 1'b0;
        waddr          = k_reg[ADDR_W-1:0];
        wdata          = take_left ? left_item : right_item;
        raddr_a        = i_reg[ADDR_W-1:0];
        raddr_b        = j_reg[ADDR_W-1:0];

        case (state_reg)
            ST_LOAD:
            begin
                waddr = count_reg[ADDR_W-1:0];
                wdata = item_t'(s_axis_tdata);
                if (in_beat)
                begin
                    b0_we      = store_ok;
                    count_next = store_ok ? count_reg + 1'b1 : count_reg;
                    ovf_next   = ovf_reg || !store_ok;
                    if (s_axis_tlast)
                    begin
                        n_next   = store_ok ? count_reg + 1'b1 : count_reg;
                        w_next   = (CNT_W+1)'(1);
                        src_next = 1'b0;
                    end
                end
            end
            ST_PASS:
            begin
                k_next = '0;
            end
            ST_RUN:
            begin
                if (pass_done)
                begin
                    w_next   = w_reg << 1;
                    src_next = !src_reg;
                end
                else
                begin
                    i_next   = k_reg;
                    mid_next = (sum_w > n_ext) ? n_reg : sum_w[CNT_W-1:0];
                    j_next   = (sum_w > n_ext) ? n_reg : sum_w[CNT_W-1:0];
                    hi_next  = (sum_2w > n_ext) ? n_reg : sum_2w[CNT_W-1:0];
                end
            end
            ST_MRD:
            begin
            end
            ST_MWR:
            begin
                b0_we  = src_reg;
                b1_we  = !src_reg;
                k_next = k_reg + 1'b1;
                if (take_left)
                begin
                    i_next = i_reg + 1'b1;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            ST_ERD:
            begin
                raddr_a = k_reg[ADDR_W-1:0];
            end
            ST_EOUT:
            begin
                raddr_a = k_reg[ADDR_W-1:0];
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = left_item;
                    out_last_next  = (k_reg + 1'b1 == n_reg);
                    out_ovf_next   = ovf_reg;
                    k_next         = k_reg + 1'b1;
                    if (k_reg + 1'b1 == n_reg)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        w_reg        <= w_next;
        k_reg        <= k_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        mid_reg      <= mid_next;
        hi_reg       <= hi_next;
        src_reg      <= src_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        out_ovf_reg  <= out_ovf_next;
    end

    // assertions
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_CNT)
        else $error("fill count beyond capacity");

    a_merge_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MWR) |-> (k_reg < hi_reg) && (hi_reg <= n_reg))
        else $error("merge write outside the current run");

    a_merge_heads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MWR) |-> (i_reg <= mid_reg) && (j_reg <= hi_reg)
                                  && ((i_reg < mid_reg) || (j_reg < hi_reg)))
        else $error("merge heads out of run bounds");

    a_batch_close: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EOUT && out_free && (k_reg + 1'b1 == n_reg))
        |=> (state_reg == ST_LOAD) && (count_reg == '0) && !ovf_reg && m_axis_tlast)
        else $error("batch not closed after final beat");

endmodule
